FILE: sv/hpq_pkg.sv
package hpq_pkg;

  // heap geometry
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_W    = 16;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // one input item
  typedef struct packed {
    cmd_e                     command;
    logic signed [KEY_W-1:0]  key;
    logic        [PAY_W-1:0]  payload;
  } hpq_in_t;

  // one result item
  typedef struct packed {
    status_e                  status;
    logic signed [KEY_W-1:0]  out_key;
    logic        [PAY_W-1:0]  out_payload;
    logic        [CNT_W-1:0]  count;
  } hpq_out_t;

  // one heap entry as stored
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic        [PAY_W-1:0]  payload;
  } hpq_entry_t;

endpackage

FILE: sv/min_heap_priority_queue.sv
// Binary min-heap priority queue of (key, payload) entries, held in one
// single-port-read synchronous RAM of CAPACITY entries. One item is worked
// at a time. An enqueue reads each parent it is compared with, pulling it
// down unless it is strictly smaller, and writes the new entry where it
// settles, at the latest at the root. A dequeue reads the root and shows it
// as its result once the read data is back, then sifts the last entry down
// from the root (per level, one RAM read for each child, a compare and a
// write back). The RAM read port is the bottleneck; a full enqueue and an
// empty dequeue finish in the cycle they are taken. A finished result sits
// in an output register with one spare slot behind it, so a stalled
// consumer holds off the next item only once both are occupied.
module min_heap_priority_queue
  import hpq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hpq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hpq_out_t out_data_o
);

  localparam int unsigned IDX_W = ADDR_W + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_DN_ROOT = 4'd3;
  localparam logic [3:0] S_DN_LAST = 4'd4;
  localparam logic [3:0] S_DN_LD   = 4'd5;
  localparam logic [3:0] S_DN_RL   = 4'd6;
  localparam logic [3:0] S_DN_RR   = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;
  localparam logic [3:0] S_DN_DEC  = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [ADDR_W-1:0] cidx_q, cidx_d;
  hpq_entry_t        ent_q, ent_d;
  hpq_entry_t        child_q, child_d;

  hpq_entry_t        heap_mem_q [CAPACITY];
  hpq_entry_t        rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  hpq_entry_t        mem_wdata;

  logic              out_valid_q;
  hpq_out_t          out_q;
  logic              pend_valid_q;
  hpq_out_t          pend_q;
  logic              res_valid;
  hpq_out_t          res;
  logic              out_free;
  logic              in_acc;

  logic [ADDR_W-1:0] par_idx;
  logic [IDX_W-1:0]  l_idx;
  logic [IDX_W-1:0]  r_idx;
  logic [IDX_W-1:0]  fill_ext;
  logic signed [KEY_W-1:0] best_key;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || pend_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // tree index arithmetic
  assign par_idx  = (idx_q - ADDR_W'(1)) >> 1;
  assign l_idx    = IDX_W'({idx_q, 1'b1});
  assign r_idx    = l_idx + IDX_W'(1);
  assign fill_ext = IDX_W'(fill_q);
  assign best_key = (child_q.key < ent_q.key) ? child_q.key : ent_q.key;

  // sequencer
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    cidx_d    = cidx_q;
    ent_d     = ent_q;
    child_d   = child_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = ent_q;
    mem_raddr = '0;
    res_valid = 1'b0;
    res       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.command == CMD_ENQ) begin
            res_valid = 1'b1;
            if (fill_q == CNT_W'(CAPACITY)) begin
              res.status = STAT_FULL;
              res.count  = fill_q;
            end else begin
              res.status    = STAT_OK;
              res.count     = fill_q + CNT_W'(1);
              fill_d        = fill_q + CNT_W'(1);
              idx_d         = fill_q[ADDR_W-1:0];
              ent_d.key     = in_data_i.key;
              ent_d.payload = in_data_i.payload;
              state_d       = S_UP_RD;
            end
          end else begin
            if (fill_q == '0) begin
              res_valid  = 1'b1;
              res.status = STAT_EMPTY;
              res.count  = '0;
            end else begin
              fill_d  = fill_q - CNT_W'(1);
              state_d = S_DN_ROOT;
            end
          end
        end
      end
      // sift up: read the parent of the hole
      S_UP_RD: begin
        if (idx_q == '0) begin
          mem_we  = 1'b1;
          state_d = S_IDLE;
        end else begin
          mem_raddr = par_idx;
          state_d   = S_UP_CMP;
        end
      end
      // stop below a strictly smaller parent, else pull the parent down
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (rdata_q.key < ent_q.key) begin
          state_d = S_IDLE;
        end else begin
          mem_wdata = rdata_q;
          idx_d     = par_idx;
          state_d   = S_UP_RD;
        end
      end
      S_DN_ROOT: begin
        mem_raddr = '0;
        state_d   = S_DN_LAST;
      end
      // root is out, fetch the last entry
      S_DN_LAST: begin
        res_valid       = 1'b1;
        res.status      = STAT_OK;
        res.out_key     = rdata_q.key;
        res.out_payload = rdata_q.payload;
        res.count       = fill_q;
        mem_raddr       = fill_q[ADDR_W-1:0];
        state_d         = S_DN_LD;
      end
      S_DN_LD: begin
        ent_d = rdata_q;
        idx_d = '0;
        if (fill_q == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_DN_RL;
        end
      end
      // sift down: read the left child, or place at a leaf
      S_DN_RL: begin
        if (l_idx >= fill_ext) begin
          mem_we  = 1'b1;
          state_d = S_IDLE;
        end else begin
          mem_raddr = l_idx[ADDR_W-1:0];
          state_d   = S_DN_RR;
        end
      end
      S_DN_RR: begin
        child_d = rdata_q;
        cidx_d  = l_idx[ADDR_W-1:0];
        if (r_idx < fill_ext) begin
          mem_raddr = r_idx[ADDR_W-1:0];
          state_d   = S_DN_CMP;
        end else begin
          state_d = S_DN_DEC;
        end
      end
      // right child wins only if strictly below the best so far
      S_DN_CMP: begin
        if (rdata_q.key < best_key) begin
          child_d = rdata_q;
          cidx_d  = r_idx[ADDR_W-1:0];
        end
        state_d = S_DN_DEC;
      end
      S_DN_DEC: begin
        mem_we = 1'b1;
        if (child_q.key < ent_q.key) begin
          mem_wdata = child_q;
          idx_d     = cidx_q;
          state_d   = S_DN_RL;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // heap storage
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= heap_mem_q[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cidx_q  <= cidx_d;
    ent_q   <= ent_d;
    child_q <= child_d;
  end

  // output register with one spare slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        if (pend_valid_q) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= 1'b0;
        end else begin
          out_valid_q <= res_valid;
        end
      end else if (res_valid) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      pend_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("spare slot used while output register empty");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("heap write while idle");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.command == CMD_ENQ && fill_q != CNT_W'(CAPACITY))
      |=> (fill_q == $past(fill_q) + CNT_W'(1)))
    else $error("enqueue did not grow the heap");

endmodule
